[hdl/sttu_pkg.sv]
// Package: shared constants, codes and command/status types for the timer table.
`timescale 1ns / 1ps
package sttu_pkg;
    localparam int NUM_TIMERS = 8;
    localparam int SLOT_W     = $clog2(NUM_TIMERS);
    localparam int US_PER_MS  = 1000;

    // Reciprocal of 1000 scaled by 2^35; exact for every sum of remainder and
    // tick length (below 2^25).
    localparam logic [25:0] TICK_RECIP       = 26'd34359739;
    localparam int          TICK_RECIP_SHIFT = 35;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CREATE  = 3'd1;
    localparam logic [2:0] MODE_START   = 3'd2;
    localparam logic [2:0] MODE_STOP    = 3'd3;
    localparam logic [2:0] MODE_DELETE  = 3'd4;
    localparam logic [2:0] MODE_SETPER  = 3'd5;
    localparam logic [2:0] MODE_SETREM  = 3'd6;
    localparam logic [2:0] MODE_POLL    = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
    localparam logic [2:0] ST_INACTIVE  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [24:0] TICK_RESET  = 25'd1000;

    // Controller to datapath commands.
    typedef struct packed {
        logic             load;      // capture request fields
        logic             tick_step; // capture whole milliseconds of the remainder
        logic             tick_fold; // add them to the uptime, keep the rest
        logic             exec;      // execute a single-result operation
        logic             poll_chk;  // not set by the controller nor read by the datapath
        logic             catchup;   // advance periodic expiry by one period
        logic             deact;     // deactivate scan slot
        logic             scan_inc;
        logic             emit;      // load output register
        logic             emit_fired;
        logic             emit_last;
    } sttu_cmd_t;

    typedef struct packed {
        logic more_hits;   // an expired timer lies beyond the scan slot
        logic slot_hit;    // scan slot expired and active
        logic need_catch;  // expiry still not past now
        logic periodic_nz; // scan slot periodic with non-zero period
        logic scan_done;
    } sttu_sts_t;
endpackage

[hdl/sttu_if.sv]
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface sttu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [3:0]  slot_num;
    logic [31:0] duration_ms;
    logic        periodic;
    modport source (output valid, mode, slot_num, duration_ms, periodic, input ready);
    modport sink   (input valid, mode, slot_num, duration_ms, periodic, output ready);
endinterface

interface sttu_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  slot_id;
    logic        fired;
    logic        last;
    logic [31:0] uptime_ms_low;
    logic [31:0] uptime_us_low;
    modport source (output valid, status, slot_id, fired, last, uptime_ms_low,
                    uptime_us_low, input ready);
    modport sink   (input valid, status, slot_id, fired, last, uptime_ms_low,
                    uptime_us_low, output ready);
endinterface

[hdl/sttu_datapath.sv]
// Datapath: uptime counters, timer table registers and result fields.
`timescale 1ns / 1ps
module sttu_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  sttu_pkg::sttu_cmd_t cmd,
    output sttu_pkg::sttu_sts_t sts,
    input  logic [24:0]         tick_period,
    input  logic [2:0]          in_mode,
    input  logic [3:0]          in_slot_num,
    input  logic [31:0]         in_duration_ms,
    input  logic                in_periodic,
    output logic [2:0]          res_status,
    output logic [2:0]          res_slot_id,
    output logic                res_fired,
    output logic                res_last,
    output logic [31:0]         res_ms_low,
    output logic [31:0]         res_us_low
);
    import sttu_pkg::*;

    logic [2:0]  mode_reg;
    logic [3:0]  id_reg;
    logic [31:0] dur_reg;
    logic        per_reg;
    logic [63:0] ms_reg;
    logic [31:0] us_reg;
    logic [24:0] rem_reg;    // remainder plus pending tick microseconds
    logic [14:0] quo_reg;    // whole milliseconds held in rem_reg
    logic [49:0] tick_prod;
    logic [24:0] quo_us;
    logic [NUM_TIMERS-1:0] alloc_reg, act_reg, perd_reg;
    logic [NUM_TIMERS-1:0] hit_vec, above_mask;
    logic [63:0] exp_reg [NUM_TIMERS];
    logic [31:0] prd_reg [NUM_TIMERS];
    logic [SLOT_W:0] scan_reg;
    logic [2:0]  st_reg, slot_out_reg;
    logic [SLOT_W-1:0] sidx;
    logic [SLOT_W-1:0] free_idx;
    logic        free_any;
    logic [SLOT_W-1:0] tid;
    logic        id_bad;
    logic [2:0]  ex_status;

    assign sidx = scan_reg[SLOT_W-1:0];
    assign tid  = id_reg[SLOT_W-1:0];
    assign id_bad = ({28'd0, id_reg} >= 32'(NUM_TIMERS));

    // Division by 1000 as a multiplication by the scaled reciprocal.
    assign tick_prod = {25'd0, rem_reg} * {24'd0, TICK_RECIP};
    assign quo_us    = {10'd0, quo_reg} * 25'(US_PER_MS);

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_idx = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            hit_vec[i]    = alloc_reg[i] && act_reg[i] && (ms_reg >= exp_reg[i]);
            above_mask[i] = (i > int'(sidx));
        end
    end

    always_comb
    begin
        ex_status = ST_OK;
        if (mode_reg == MODE_CREATE)
            ex_status = free_any ? ST_OK : ST_FULL;
        else if (mode_reg == MODE_TICK)
            ex_status = ST_OK;
        else if (id_bad)
            ex_status = ST_BAD_ID;
        else if (!alloc_reg[tid])
            ex_status = ST_NOT_ALLOC;
        else if (mode_reg == MODE_SETREM && !act_reg[tid])
            ex_status = ST_INACTIVE;
    end

    assign sts.more_hits   = |(hit_vec & above_mask);
    assign sts.slot_hit    = hit_vec[sidx];
    assign sts.need_catch  = (ms_reg >= exp_reg[sidx]);
    assign sts.periodic_nz = perd_reg[sidx] && (prd_reg[sidx] != 32'd0);
    assign sts.scan_done   = (scan_reg == (SLOT_W+1)'(NUM_TIMERS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_TICK;
            id_reg       <= '0;
            dur_reg      <= '0;
            per_reg      <= 1'b0;
            ms_reg       <= '0;
            us_reg       <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            alloc_reg    <= '0;
            act_reg      <= '0;
            perd_reg     <= '0;
            scan_reg     <= '0;
            st_reg       <= ST_OK;
            slot_out_reg <= '0;
            res_fired    <= 1'b0;
            res_last     <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                exp_reg[i] <= '0;
                prd_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                mode_reg <= in_mode;
                id_reg   <= in_slot_num;
                dur_reg  <= in_duration_ms;
                per_reg  <= in_periodic;
                scan_reg <= '0;
                if (in_mode == MODE_TICK)
                begin
                    us_reg  <= us_reg + {7'd0, tick_period};
                    rem_reg <= rem_reg + tick_period;
                end
            end
            if (cmd.tick_step)
                quo_reg <= tick_prod[TICK_RECIP_SHIFT+14:TICK_RECIP_SHIFT];
            if (cmd.tick_fold)
            begin
                ms_reg  <= ms_reg + {49'd0, quo_reg};
                rem_reg <= rem_reg - quo_us;
            end
            if (cmd.exec && ex_status == ST_OK)
            begin
                unique case (mode_reg)
                    MODE_CREATE:
                    begin
                        alloc_reg[free_idx] <= 1'b1;
                        act_reg[free_idx]   <= 1'b0;
                        perd_reg[free_idx]  <= per_reg;
                        exp_reg[free_idx]   <= '0;
                        prd_reg[free_idx]   <= dur_reg;
                    end
                    MODE_START:
                    begin
                        exp_reg[tid] <= ms_reg + {32'd0, prd_reg[tid]};
                        act_reg[tid] <= 1'b1;
                    end
                    MODE_STOP:
                        act_reg[tid] <= 1'b0;
                    MODE_DELETE:
                    begin
                        alloc_reg[tid] <= 1'b0;
                        act_reg[tid]   <= 1'b0;
                        perd_reg[tid]  <= 1'b0;
                        exp_reg[tid]   <= '0;
                        prd_reg[tid]   <= '0;
                    end
                    MODE_SETPER:
                    begin
                        prd_reg[tid] <= dur_reg;
                        if (act_reg[tid])
                            exp_reg[tid] <= ms_reg + {32'd0, dur_reg};
                    end
                    MODE_SETREM:
                        exp_reg[tid] <= ms_reg + {32'd0, dur_reg};
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.catchup)
                exp_reg[sidx] <= exp_reg[sidx] + {32'd0, prd_reg[sidx]};
            if (cmd.deact)
                act_reg[sidx] <= 1'b0;
            if (cmd.scan_inc)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.emit)
            begin
                if (cmd.emit_fired)
                begin
                    st_reg       <= ST_OK;
                    slot_out_reg <= 3'(sidx);
                end
                else if (mode_reg == MODE_POLL)
                begin
                    st_reg       <= ST_OK;
                    slot_out_reg <= '0;
                end
                else
                begin
                    st_reg       <= ex_status;
                    slot_out_reg <= (mode_reg == MODE_CREATE && free_any) ? 3'(free_idx) : 3'd0;
                end
                res_fired <= cmd.emit_fired;
                res_last  <= cmd.emit_last;
            end
        end
    end

    assign res_status  = st_reg;
    assign res_slot_id = slot_out_reg;
    assign res_ms_low  = ms_reg[31:0];
    assign res_us_low  = us_reg;
endmodule

[hdl/sttu_ctrl.sv]
// Controller: sequences ticks, single operations and the poll scan.
`timescale 1ns / 1ps
module sttu_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_mode,
    output logic                out_valid,
    input  logic                out_ready,
    output sttu_pkg::sttu_cmd_t cmd,
    input  sttu_pkg::sttu_sts_t sts
);
    import sttu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CATCH = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_FOLD  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       any_reg, any_next;
    logic [3:0] cnt_reg, cnt_next;

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        any_next   = any_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    any_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = (in_mode == MODE_TICK) ? S_TICK :
                                 (in_mode == MODE_POLL) ? S_SCAN : S_EXEC;
                end
            S_TICK:
            begin
                cmd.tick_step = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.tick_fold = 1'b1;
                cmd.emit = 1'b1;
                cmd.emit_last = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.emit = 1'b1;
                cmd.emit_last = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
                if (ov_reg)
                begin
                end
                else if (sts.scan_done || cnt_reg == 4'd8)
                begin
                    if (!any_reg)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_last = 1'b1;
                        ov_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (sts.slot_hit)
                begin
                    if (sts.periodic_nz)
                    begin
                        cmd.catchup = 1'b1;
                        state_next = S_CATCH;
                    end
                    else
                    begin
                        cmd.deact = 1'b1;
                        state_next = S_WAIT;
                    end
                end
                else
                    cmd.scan_inc = 1'b1;
            S_CATCH:
                if (sts.need_catch)
                    cmd.catchup = 1'b1;
                else
                    state_next = S_WAIT;
            S_WAIT:
            begin
                // The result is the last one when no later slot has expired.
                cmd.emit = 1'b1;
                cmd.emit_fired = 1'b1;
                cmd.emit_last = !sts.more_hits;
                ov_next = 1'b1;
                any_next = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                cmd.scan_inc = 1'b1;
                state_next = S_SCAN;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            any_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            any_reg   <= any_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule

[hdl/software_timer_table_with_uptime.sv]
// Top level: polled software timer table with microsecond and millisecond uptime.
`timescale 1ns / 1ps
// One request at a time: the next request is taken only once the previous one
// has finished and its last result has been accepted. An operation other than
// tick or poll runs in the execute state, which registers its result. A tick
// adds the tick length as the request is taken, finds the whole milliseconds
// of the remainder by a reciprocal multiplication and then folds them into the
// uptime. A poll visits the eight slots one per cycle while no fired timer is
// handled; a fired timer is deactivated, or if periodic with a non-zero period
// caught up one period per step, and its result must be accepted before the
// scan goes on, so the poll length depends on how far behind the timers are.
// Poll results for fired timers are reported in slot order and the last flag
// rides on the final one; a poll with none fired returns one result with the
// last flag. The uptime fields show the counters at delivery.
module software_timer_table_with_uptime
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [24:0]  cfg_wdata,
    sttu_req_if.sink     req,
    sttu_res_if.source   res
);
    import sttu_pkg::*;

    logic [24:0] tick_reg;
    sttu_cmd_t   cmd;
    sttu_sts_t   sts;
    logic        fired_raw, last_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_reg <= TICK_RESET;
        else if (cfg_we)
            tick_reg <= cfg_wdata;
    end

    sttu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_mode   (req.mode),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sttu_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .tick_period    (tick_reg),
        .in_mode        (req.mode),
        .in_slot_num    (req.slot_num),
        .in_duration_ms (req.duration_ms),
        .in_periodic    (req.periodic),
        .res_status     (res.status),
        .res_slot_id    (res.slot_id),
        .res_fired      (fired_raw),
        .res_last       (last_raw),
        .res_ms_low     (res.uptime_ms_low),
        .res_us_low     (res.uptime_us_low)
    );

    assign res.fired = fired_raw;
    assign res.last  = last_raw;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !req.ready) else $error("request accepted while result pending");
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.fired) |-> (res.status == ST_OK)) else $error("fired with error");
`endif
endmodule

[tb/sttu_checker.sv]
// Checker: watches the request and result channels, predicts results and compares them.
`timescale 1ns / 1ps
module sttu_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [24:0] cfg_wdata,
    sttu_req_if         req,
    sttu_res_if         res,
    output int          errors,
    output int          pending
);
    import sttu_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot_id;
        logic        fired;
        logic        last;
        logic [31:0] ms_low;
        logic [31:0] us_low;
    } timer_result_t;

    timer_result_t expected_results[$];

    logic [24:0] tick_len_us;
    logic [63:0] up_ms;
    logic [31:0] up_us;
    logic [9:0]  sub_ms;
    logic        t_alloc   [NUM_TIMERS];
    logic        t_active  [NUM_TIMERS];
    logic        t_periodic[NUM_TIMERS];
    logic [63:0] t_expiry  [NUM_TIMERS];
    logic [31:0] t_period  [NUM_TIMERS];

    task automatic clear_timer(input int i);
        t_alloc[i]    = 1'b0;
        t_active[i]   = 1'b0;
        t_periodic[i] = 1'b0;
        t_expiry[i]   = '0;
        t_period[i]   = '0;
    endtask

    task automatic push_result(input logic [2:0] st, input logic [2:0] sl,
                               input logic fi, input logic la);
        timer_result_t r;
        r.status  = st;
        r.slot_id = sl;
        r.fired   = fi;
        r.last    = la;
        r.ms_low  = up_ms[31:0];
        r.us_low  = up_us;
        expected_results.push_back(r);
    endtask

    // Applies one request to the local copy of the timer table.
    task automatic predict_request(input logic [2:0] mode, input logic [3:0] id,
                                   input logic [31:0] dur, input logic per);
        logic [2:0]  st;
        logic [2:0]  sl;
        logic [31:0] total;
        logic [63:0] k;
        int          fired_n;
        st = ST_OK;
        sl = '0;
        if (mode == MODE_TICK)
        begin
            total  = {22'd0, sub_ms} + {7'd0, tick_len_us};
            up_us  = up_us + {7'd0, tick_len_us};
            up_ms  = up_ms + 64'(total / US_PER_MS);
            sub_ms = 10'(total % US_PER_MS);
        end
        else if (mode == MODE_CREATE)
        begin
            st = ST_FULL;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (!t_alloc[i] && st == ST_FULL)
                begin
                    clear_timer(i);
                    t_alloc[i]    = 1'b1;
                    t_periodic[i] = per;
                    t_period[i]   = dur;
                    st = ST_OK;
                    sl = 3'(i);
                end
            end
        end
        else if (mode == MODE_POLL)
        begin
            fired_n = 0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (t_alloc[i] && t_active[i] && up_ms >= t_expiry[i])
                begin
                    if (t_periodic[i] && t_period[i] != 0)
                    begin
                        k = (up_ms - t_expiry[i]) / {32'd0, t_period[i]} + 64'd1;
                        t_expiry[i] = t_expiry[i] + k * {32'd0, t_period[i]};
                    end
                    else
                        t_active[i] = 1'b0;
                    push_result(ST_OK, 3'(i), 1'b1, 1'b0);
                    fired_n++;
                end
            end
            if (fired_n == 0)
                push_result(ST_OK, 3'd0, 1'b0, 1'b1);
            else
                expected_results[$].last = 1'b1;
            return;
        end
        else if (id >= NUM_TIMERS)
            st = ST_BAD_ID;
        else if (!t_alloc[id])
            st = ST_NOT_ALLOC;
        else if (mode == MODE_START)
        begin
            t_expiry[id] = up_ms + {32'd0, t_period[id]};
            t_active[id] = 1'b1;
        end
        else if (mode == MODE_STOP)
            t_active[id] = 1'b0;
        else if (mode == MODE_DELETE)
            clear_timer(id);
        else if (mode == MODE_SETPER)
        begin
            t_period[id] = dur;
            if (t_active[id])
                t_expiry[id] = up_ms + {32'd0, dur};
        end
        else if (!t_active[id])
            st = ST_INACTIVE;
        else
            t_expiry[id] = up_ms + {32'd0, dur};
        push_result(st, sl, 1'b0, 1'b1);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v, inout int errs);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t exp_r;
        int            errs;
        if (!rst_n)
        begin
            tick_len_us = TICK_RESET;
            up_ms  = '0;
            up_us  = '0;
            sub_ms = '0;
            for (int i = 0; i < NUM_TIMERS; i++)
                clear_timer(i);
            expected_results.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            errs = errors;
            if (cfg_we)
                tick_len_us = cfg_wdata;
            if (req.valid && req.ready)
                predict_request(req.mode, req.slot_num, req.duration_ms, req.periodic);
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d slot %0d", $time,
                             res.status, res.slot_id);
                    errs++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(res.status), errs);
                    check_field("slot_id", 32'(exp_r.slot_id), 32'(res.slot_id), errs);
                    check_field("fired", 32'(exp_r.fired), 32'(res.fired), errs);
                    check_field("last", 32'(exp_r.last), 32'(res.last), errs);
                    check_field("uptime_ms_low", exp_r.ms_low, res.uptime_ms_low, errs);
                    check_field("uptime_us_low", exp_r.us_low, res.uptime_us_low, errs);
                end
            end
            errors  <= errs;
            pending <= expected_results.size();
        end
    end
endmodule

[tb/tb_top.sv]
// Testbench top: clock, reset, request stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps
module tb_top;
    import sttu_pkg::*;

    // Cycles without any handshake before the run is declared hung. The slowest
    // legitimate gap is a poll whose periodic timers have fallen many periods
    // behind; the longest ticks are only sent with an empty table so that no poll
    // has to catch up after them.
    localparam int STALL_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [24:0] cfg_wdata;
    int          errors;
    int          pending;
    int          quiet_cycles;
    // When set, neither side inserts idle cycles.
    logic        calm;

    sttu_req_if req ();
    sttu_res_if res ();

    software_timer_table_with_uptime u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res       (res)
    );

    sttu_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The result side stalls with a probability of roughly 30 percent unless calm.
    always @(posedge clk)
        res.ready <= calm || ($urandom_range(99) >= 30);

    // Watchdog: any accepted request or result resets the count.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Presents one request and waits until it is taken. Valid stays high after
    // acceptance so that back-to-back requests never toggle it within a step;
    // it is lowered only for an idle gap, a tick length change or the end of the run.
    task automatic send_request(input logic [2:0] mode, input logic [3:0] id,
                                input logic [31:0] dur, input logic per);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 30)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= mode;
        req.slot_num    <= id;
        req.duration_ms <= dur;
        req.periodic    <= per;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Lets the block run dry, then writes the tick length while it is idle.
    task automatic set_tick_length(input logic [24:0] value);
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random request. Most addresses are valid slots and most durations
    // are short so that timers actually expire while ticks are going on.
    task automatic random_request();
        int          pick;
        logic [2:0]  mode;
        logic [3:0]  id;
        logic [31:0] dur;
        pick = $urandom_range(99);
        if (pick < 30)
            mode = MODE_TICK;
        else if (pick < 42)
            mode = MODE_CREATE;
        else if (pick < 54)
            mode = MODE_START;
        else if (pick < 60)
            mode = MODE_STOP;
        else if (pick < 66)
            mode = MODE_DELETE;
        else if (pick < 74)
            mode = MODE_SETPER;
        else if (pick < 82)
            mode = MODE_SETREM;
        else
            mode = MODE_POLL;
        if ($urandom_range(99) < 85)
            id = 4'($urandom_range(NUM_TIMERS - 1));
        else
            id = 4'($urandom_range(15, NUM_TIMERS));
        if ($urandom_range(99) < 5)
            dur = $urandom;
        else
            dur = $urandom_range(20);
        send_request(mode, id, dur, 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        calm            <= 1'b0;
        req.valid       <= 1'b0;
        req.mode        <= MODE_TICK;
        req.slot_num    <= '0;
        req.duration_ms <= '0;
        req.periodic    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset tick length: a zero-length one-shot, a
        // short periodic, a periodic with zero period and a one-shot at the
        // longest duration, then the error paths and a full table.
        send_request(MODE_CREATE, 4'd0, 32'd0, 1'b0);
        send_request(MODE_CREATE, 4'd0, 32'd3, 1'b1);
        send_request(MODE_CREATE, 4'd0, 32'd0, 1'b1);
        send_request(MODE_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < 4; i++)
            send_request(MODE_START, 4'(i), 32'd0, 1'b0);
        send_request(MODE_POLL, 4'd0, 32'd0, 1'b0);
        repeat (7) send_request(MODE_TICK, 4'd0, 32'd0, 1'b0);
        send_request(MODE_POLL, 4'd0, 32'd0, 1'b0);
        send_request(MODE_STOP, 4'd1, 32'd0, 1'b0);
        send_request(MODE_SETREM, 4'd1, 32'd5, 1'b0);
        send_request(MODE_SETPER, 4'd1, 32'd2, 1'b0);
        send_request(MODE_START, 4'd1, 32'd0, 1'b0);
        send_request(MODE_SETREM, 4'd15, 32'd1, 1'b0);
        send_request(MODE_DELETE, 4'd7, 32'd0, 1'b0);
        repeat (5) send_request(MODE_CREATE, 4'd0, 32'd1, 1'b1);
        send_request(MODE_DELETE, 4'd3, 32'd0, 1'b0);
        send_request(MODE_SETREM, 4'd3, 32'd1, 1'b0);
        send_request(MODE_STOP, 4'd8, 32'd0, 1'b0);

        // Every slot started with a zero period so that one poll fires all eight.
        send_request(MODE_CREATE, 4'd0, 32'd0, 1'b1);
        for (int i = 0; i < NUM_TIMERS; i++)
            send_request(MODE_SETPER, 4'(i), 32'd0, 1'b0);
        for (int i = 0; i < NUM_TIMERS; i++)
            send_request(MODE_START, 4'(i), 32'd0, 1'b0);
        send_request(MODE_POLL, 4'd0, 32'd0, 1'b0);

        // Random phases at various tick lengths; the second runs without idling.
        for (int phase = 0; phase < 4; phase++)
        begin
            set_tick_length(phase == 0 ? 25'd1 : 25'($urandom_range(5000, 2)));
            calm <= (phase == 1);
            repeat (70) random_request();
        end
        calm <= 1'b0;

        // Extreme tick lengths with an empty table, so polls have nothing to catch
        // up: a large power of two, zero and that power less one, then random requests.
        for (int i = 0; i < NUM_TIMERS; i++)
            send_request(MODE_DELETE, 4'(i), 32'd0, 1'b0);
        set_tick_length(25'd16777216);
        repeat (2) send_request(MODE_TICK, 4'd0, 32'd0, 1'b0);
        send_request(MODE_POLL, 4'd0, 32'd0, 1'b0);
        set_tick_length(25'd0);
        send_request(MODE_TICK, 4'd0, 32'd0, 1'b0);
        set_tick_length(25'h0FF_FFFF);
        send_request(MODE_TICK, 4'd0, 32'd0, 1'b0);
        set_tick_length(25'($urandom_range(3000, 500)));
        repeat (30) random_request();

        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
